### rtl/core/drrs_pkg.sv
// ============================================================================
// drrs_pkg
// Shared widths, constants, sequencer states and the emit control bundle of
// the date-ranked retention sorter.
// ============================================================================
package drrs_pkg;

    // field widths
    localparam int TAG_W  = 16;
    localparam int DATE_W = 32;
    localparam int KEEP_W = 7;
    localparam int RANK_W = 6;
    localparam int WORD_W = DATE_W + TAG_W;

    // store sizing: results are ranked in RANK_W bits
    localparam int CAP_LIMIT        = 64;
    localparam int DEF_MAX_ENTRIES  = 64;

    localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(8);

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_INS_PUT,
        ST_EMIT_CHK,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_HOLD
    } seq_state_t;

    // sequencer to output stage
    typedef struct packed {
        logic              load;
        logic [RANK_W-1:0] rank;
        logic              final_flag;
        logic              ovf;
    } emit_t;

endpackage

### rtl/core/drrs_ram.sv
// ============================================================================
// drrs_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ============================================================================
module drrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/drrs_seq.sv
// ============================================================================
// drrs_seq
// Insertion and emission sequencer. Inserts an entry by walking down from
// the fill level, moving older entries up one slot, then walks the store in
// rank order to emit results.
// ============================================================================
module drrs_seq
    import drrs_pkg::*;
#(
    parameter int CAP = DEF_MAX_ENTRIES
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // input channel
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [TAG_W-1:0]       entry_tag,
    input  logic [DATE_W-1:0]      date_word,
    input  logic                   last,
    // store port
    output logic                   ram_we,
    output logic [$clog2(CAP)-1:0] ram_waddr,
    output logic [WORD_W-1:0]      ram_wdata,
    output logic                   ram_re,
    output logic [$clog2(CAP)-1:0] ram_raddr,
    input  logic [WORD_W-1:0]      ram_rdata,
    // output stage
    input  logic                   out_accept,
    output emit_t                  emit
);

    localparam int AW = $clog2(CAP);
    localparam int CW = $clog2(CAP + 1);

    seq_state_t state_reg, state_next;

    logic [CW-1:0]     count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [AW-1:0]     pos_reg, pos_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [TAG_W-1:0]  tag_hold_reg, tag_hold_next;
    logic [DATE_W-1:0] date_hold_reg, date_hold_next;
    logic              last_hold_reg, last_hold_next;

    logic in_accept;
    logic entry_ok;
    logic store_full;
    logic rd_newer;
    logic is_final;

    assign in_accept  = in_valid && in_ready;
    assign entry_ok   = (date_word != '0);
    assign store_full = (count_reg >= CW'(CAP));
    // stored entry is equal or newer: new entry lands above it
    assign rd_newer   = (ram_rdata[WORD_W-1:TAG_W] >= date_hold_reg);
    assign is_final   = ((CW'(idx_reg) + CW'(1)) == count_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (entry_ok && !store_full)
                    begin
                        state_next = (count_reg == '0) ? ST_INS_PUT : ST_INS_RD;
                    end
                    else if (last)
                    begin
                        state_next = ST_EMIT_CHK;
                    end
                end
            end
            ST_INS_RD:
            begin
                state_next = ST_INS_CMP;
            end
            ST_INS_CMP:
            begin
                if (rd_newer)
                begin
                    state_next = last_hold_reg ? ST_EMIT_CHK : ST_IDLE;
                end
                else
                begin
                    state_next = (pos_reg == AW'(1)) ? ST_INS_PUT : ST_INS_RD;
                end
            end
            ST_INS_PUT:
            begin
                state_next = last_hold_reg ? ST_EMIT_CHK : ST_IDLE;
            end
            ST_EMIT_CHK:
            begin
                state_next = (count_reg == '0) ? ST_IDLE : ST_EMIT_RD;
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                state_next = ST_EMIT_HOLD;
            end
            ST_EMIT_HOLD:
            begin
                if (out_accept)
                begin
                    state_next = is_final ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath registers next values
    always_comb
    begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        tag_hold_next  = tag_hold_reg;
        date_hold_next = date_hold_reg;
        last_hold_next = last_hold_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    tag_hold_next  = entry_tag;
                    date_hold_next = date_word;
                    last_hold_next = last;
                    pos_next       = AW'(count_reg);
                    if (entry_ok && store_full)
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            ST_INS_CMP:
            begin
                if (rd_newer)
                begin
                    count_next = count_reg + CW'(1);
                end
                else
                begin
                    pos_next = pos_reg - AW'(1);
                end
            end
            ST_INS_PUT:
            begin
                count_next = count_reg + CW'(1);
            end
            ST_EMIT_CHK:
            begin
                idx_next = '0;
                if (count_reg == '0)
                begin
                    ovf_next = 1'b0;
                end
            end
            ST_EMIT_HOLD:
            begin
                if (out_accept)
                begin
                    if (is_final)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg + AW'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready        = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = pos_reg;
        ram_wdata       = {date_hold_reg, tag_hold_reg};
        ram_re          = 1'b0;
        ram_raddr       = idx_reg;
        emit.load       = 1'b0;
        emit.rank       = RANK_W'(idx_reg);
        emit.final_flag = is_final;
        emit.ovf        = ovf_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_INS_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = pos_reg - AW'(1);
            end
            ST_INS_CMP:
            begin
                // either place the new entry or move the older one up a slot
                ram_we = 1'b1;
                if (!rd_newer)
                begin
                    ram_wdata = ram_rdata;
                end
            end
            ST_INS_PUT:
            begin
                ram_we = 1'b1;
            end
            ST_EMIT_RD:
            begin
                ram_re = 1'b1;
            end
            ST_EMIT_LD:
            begin
                emit.load = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            last_hold_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            last_hold_reg <= last_hold_next;
        end
    end

    // payload and index registers
    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        idx_reg       <= idx_next;
        tag_hold_reg  <= tag_hold_next;
        date_hold_reg <= date_hold_next;
    end

endmodule

### rtl/core/date_ranked_retention_sorter_unit.sv
// ============================================================================
// date_ranked_retention_sorter_unit
// Stable newest-first sorter of dated entries held in one RAM, with ranked
// results carrying retain and overflow flags.
// ============================================================================
// Insert: each moved entry costs one RAM read and one write; an entry landing
//   at rank 0 is written by the final put state.
// Emit: a check state, then read, load and hold states per result; the hold
//   state waits out any output stall. One transaction at a time.
// Reset: fill count and overflow flag cleared, retain limit set to 8; RAM
//   contents are left undefined and never read before being written.
module date_ranked_retention_sorter_unit
    import drrs_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  logic              clk,
    input  logic              rst_n,
    // configuration
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [KEEP_W-1:0] cfg_data,
    // input channel
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [TAG_W-1:0]  entry_tag,
    input  logic [DATE_W-1:0] date_word,
    input  logic              last,
    // output channel
    output logic              out_valid,
    input  logic              out_ready,
    output logic [TAG_W-1:0]  entry_tag_res,
    output logic [RANK_W-1:0] rank,
    output logic              retain,
    output logic              overflow,
    output logic              final_res
);

    localparam int CAP = (MAX_ENTRIES < CAP_LIMIT) ? MAX_ENTRIES : CAP_LIMIT;
    localparam int AW  = $clog2(CAP);

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;
    emit_t             emit;
    logic              out_accept;

    logic [KEEP_W-1:0] retain_limit_reg;
    logic              out_valid_reg, out_valid_next;
    logic [TAG_W-1:0]  tag_res_reg;
    logic [RANK_W-1:0] rank_reg;
    logic              retain_reg;
    logic              ovf_res_reg;
    logic              final_reg;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retain_limit_reg <= KEEP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            retain_limit_reg <= cfg_data;
        end
    end

    // entry store
    drrs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAP)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sequencer
    drrs_seq #(
        .CAP (CAP)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .entry_tag  (entry_tag),
        .date_word  (date_word),
        .last       (last),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .out_accept (out_accept),
        .emit       (emit)
    );

    // output register
    assign out_accept = out_valid_reg && out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_accept)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload; a retain limit of zero retains everything
    always_ff @(posedge clk)
    begin
        if (emit.load)
        begin
            tag_res_reg <= ram_rdata[TAG_W-1:0];
            rank_reg    <= emit.rank;
            retain_reg  <= (retain_limit_reg == '0) ||
                           ({1'b0, emit.rank} < retain_limit_reg);
            ovf_res_reg <= emit.ovf;
            final_reg   <= emit.final_flag;
        end
    end

    assign out_valid     = out_valid_reg;
    assign entry_tag_res = tag_res_reg;
    assign rank          = rank_reg;
    assign retain        = retain_reg;
    assign overflow      = ovf_res_reg;
    assign final_res     = final_reg;

endmodule

### rtl/core/drrs_checker.sv
// ============================================================================
// drrs_checker
// Port-level checks of the sorter: result hold, exclusive load and emit phases,
// run continuity, input busy after a last entry and retention of the newest entry.
// ============================================================================
module drrs_checker
    import drrs_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              last,
    input logic              out_valid,
    input logic              out_ready,
    input logic [TAG_W-1:0]  entry_tag_res,
    input logic [RANK_W-1:0] rank,
    input logic              retain,
    input logic              final_res
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(entry_tag_res) && $stable(rank))
        else $error("stalled result changed");

    // loading and emitting never overlap
    a_phase_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while a result is pending");

    // a non-final result means more results follow before any new entry
    a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !final_res |=> !in_ready)
        else $error("input reopened in the middle of a result run");

    // a last entry always takes the sequencer out of idle
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last |=> !in_ready)
        else $error("input ready right after a last transaction");

    // the newest entry is always retained
    a_rank0_keep: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (rank == '0) |-> retain)
        else $error("rank zero not retained");

endmodule

bind date_ranked_retention_sorter_unit drrs_checker u_drrs_checker (.*);
